// File: rtl/rwc_pkg.sv
// Shared types and constants for the repeat window classifier.
// No dependencies; imported by repeat_window_classifier_top.
package rwc_pkg;

   // Default sizes, handed to the top level parameters
   localparam int unsigned HALF_WINDOW_DEF  = 150;
   localparam int unsigned MAX_READ_LEN_DEF = 1048576;

   // Field widths fixed by the stream and register formats
   localparam int unsigned FREQ_W      = 16;
   localparam int unsigned THRESH_W    = 16;
   localparam int unsigned RATIO_W     = 14;
   localparam int unsigned POS_OUT_W   = 20;
   localparam int unsigned REQ_TDATA_W = 24;
   localparam int unsigned RSP_TDATA_W = 24;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned REG_SEL_BIT = 2;

   // Ratio is in units of 1/10000
   localparam logic [RATIO_W-1:0] RATIO_SCALE = 14'd10000;

   // Register reset values
   localparam logic [THRESH_W-1:0] REPEAT_THRESHOLD_RST = 16'd100;
   localparam logic [RATIO_W-1:0]  RATIO_THRESHOLD_RST  = 14'd195;

   // Input command codes
   typedef enum logic {
      CMD_KMER  = 1'b0,
      CMD_DRAIN = 1'b1
   } cmd_type;

   // Register select codes (address bit 2)
   typedef enum logic {
      CSR_REPEAT_THRESHOLD = 1'b0,
      CSR_RATIO_THRESHOLD  = 1'b1
   } csr_sel_type;

   // Per-position class
   typedef enum logic [1:0] {
      CLS_UNIQUE  = 2'd0,
      CLS_REPEAT  = 2'd1,
      CLS_GARBAGE = 2'd2
   } class_type;

endpackage

// File: rtl/repeat_window_classifier_top.sv
// Repeat window classifier: per-position repeat/unique decision over a
// centered window of k-mer classes. Depends on rwc_pkg.
//
//  channel | dir | transfer                      | payload
//  req_    | in  | req_tvalid & req_tready       | tuser command, tdata freq/low_complexity
//  rsp_    | out | rsp_tvalid & rsp_tready       | tdata position/repeat_mode, tlast last_of_read
//  csr_    | in  | psel & penable & pwrite       | repeat_threshold @0, ratio_threshold @4
//
// One item per cycle sustained while the result stream is not stalled. A
// request passes an input register, then the window update and ratio
// compare into the result register.
// Window classes live in a shift line of 2*HALF_WINDOW+1 entries that
// advances on every position taken in and every drain step that emits a result.
// Synchronous active-high reset clears counts, positions and both valids.
// A stalled result holds the input register only when that item yields a
// result; items without a result still move on.
module repeat_window_classifier_top #(
   parameter int unsigned HALF_WINDOW  = rwc_pkg::HALF_WINDOW_DEF,
   parameter int unsigned MAX_READ_LEN = rwc_pkg::MAX_READ_LEN_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: [15:0] kmer_freq, [16] low_complexity, [23:17] zero
   input  logic [rwc_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // tuser: [0] command
   input  logic                                req_tuser,
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: [19:0] position, [20] repeat_mode, [23:21] zero
   output logic [rwc_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rwc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [rwc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [rwc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import rwc_pkg::*;

   localparam int unsigned WIN_LEN = 2 * HALF_WINDOW + 1;
   localparam int unsigned CNT_W   = $clog2(WIN_LEN + 1);
   localparam int unsigned POS_W   = $clog2(MAX_READ_LEN + 1);
   localparam int unsigned PROD_W  = CNT_W + RATIO_W;

   // Configuration registers
   logic [THRESH_W-1:0] rep_thresh_ff;
   logic [RATIO_W-1:0]  ratio_thresh_ff;

   // Input register
   logic                in_valid_ff;
   cmd_type             in_cmd_ff;
   logic [FREQ_W-1:0]   in_freq_ff;
   logic                in_lowc_ff;

   // Read state
   logic [CNT_W-1:0]    rep_cnt_ff;
   logic [CNT_W-1:0]    garb_cnt_ff;
   logic [POS_W-1:0]    next_in_ff;
   logic [POS_W-1:0]    next_out_ff;
   class_type           class_line_ff [WIN_LEN];

   // Result register
   logic                 out_valid_ff;
   logic [POS_OUT_W-1:0] out_pos_ff;
   logic                 out_mode_ff;
   logic                 out_last_ff;

   // Combinational step
   logic                is_kmer;
   logic                kmer_take;
   logic                kmer_emit;
   logic                drain_emit;
   logic                drain_clear;
   logic                has_result;
   logic                step_go;
   logic                shift_en;
   logic                drop_en;
   class_type           new_cls;
   class_type           old_cls;
   logic [CNT_W-1:0]    rep_drop;
   logic [CNT_W-1:0]    garb_drop;
   logic [CNT_W-1:0]    rep_in;
   logic [CNT_W-1:0]    garb_in;
   logic [POS_W-1:0]    cur_pos;
   logic [POS_W-1:0]    right_pos;
   logic [POS_W-1:0]    left_pos;
   logic [POS_W-1:0]    win_size;
   logic [POS_W-1:0]    garb_ext;
   logic [CNT_W-1:0]    good_cnt;
   logic [PROD_W-1:0]   rep_prod;
   logic [PROD_W-1:0]   ratio_prod;
   logic                mode;
   logic                last;

   // Register port: writes land on the access phase, pready tied high
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rep_thresh_ff   <= REPEAT_THRESHOLD_RST;
         ratio_thresh_ff <= RATIO_THRESHOLD_RST;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         unique case (csr_sel_type'(csr_paddr[REG_SEL_BIT]))
            CSR_REPEAT_THRESHOLD: rep_thresh_ff   <= csr_pwdata[THRESH_W-1:0];
            CSR_RATIO_THRESHOLD:  ratio_thresh_ff <= csr_pwdata[RATIO_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel_type'(csr_paddr[REG_SEL_BIT]))
         CSR_REPEAT_THRESHOLD: csr_prdata = CSR_DATA_W'(rep_thresh_ff);
         CSR_RATIO_THRESHOLD:  csr_prdata = CSR_DATA_W'(ratio_thresh_ff);
         default:              csr_prdata = '0;
      endcase
   end

   // Decode the held item
   always_comb begin
      is_kmer     = (in_cmd_ff == CMD_KMER);
      kmer_take   = is_kmer && (32'(next_in_ff) < MAX_READ_LEN);
      kmer_emit   = kmer_take && (32'(next_in_ff) >= HALF_WINDOW);
      drain_emit  = !is_kmer && (next_out_ff < next_in_ff);
      drain_clear = !is_kmer && !drain_emit;
      has_result  = kmer_emit || drain_emit;
      step_go     = in_valid_ff && (!has_result || !out_valid_ff || rsp_tready);
      shift_en    = step_go && (kmer_take || drain_emit);
   end

   // Input register doubles as the skid stage
   assign req_tready = !in_valid_ff || step_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff  <= cmd_type'(req_tuser);
         in_freq_ff <= req_tdata[FREQ_W-1:0];
         in_lowc_ff <= req_tdata[FREQ_W];
      end
   end

   // Classify the new k-mer and pick the class leaving the window
   always_comb begin
      if (in_lowc_ff) begin
         new_cls = CLS_GARBAGE;
      end else if (in_freq_ff >= rep_thresh_ff) begin
         new_cls = CLS_REPEAT;
      end else begin
         new_cls = CLS_UNIQUE;
      end
      old_cls = class_line_ff[WIN_LEN-1];
      if (kmer_take) begin
         drop_en = (32'(next_in_ff) >= WIN_LEN);
      end else begin
         drop_en = drain_emit && (32'(next_out_ff) >= HALF_WINDOW + 1);
      end
   end

   // Update counts: drop first, then add
   always_comb begin
      rep_drop  = rep_cnt_ff;
      garb_drop = garb_cnt_ff;
      if (drop_en && (old_cls == CLS_REPEAT) && (rep_cnt_ff != '0)) begin
         rep_drop = rep_cnt_ff - CNT_W'(1);
      end
      if (drop_en && (old_cls == CLS_GARBAGE) && (garb_cnt_ff != '0)) begin
         garb_drop = garb_cnt_ff - CNT_W'(1);
      end
      rep_in  = rep_drop  + CNT_W'(kmer_take && (new_cls == CLS_REPEAT));
      garb_in = garb_drop + CNT_W'(kmer_take && (new_cls == CLS_GARBAGE));
   end

   // Window bounds and ratio decision
   always_comb begin
      if (is_kmer) begin
         cur_pos   = next_in_ff - POS_W'(HALF_WINDOW);
         right_pos = next_in_ff;
      end else begin
         cur_pos   = next_out_ff;
         right_pos = next_in_ff - POS_W'(1);
      end
      if (32'(cur_pos) >= HALF_WINDOW) begin
         left_pos = cur_pos - POS_W'(HALF_WINDOW);
      end else begin
         left_pos = '0;
      end
      win_size = right_pos - left_pos + POS_W'(1);
      garb_ext = POS_W'(garb_in);
      if (win_size > garb_ext) begin
         good_cnt = CNT_W'(win_size - garb_ext);
      end else begin
         good_cnt = '0;
      end
      rep_prod   = PROD_W'(rep_in) * PROD_W'(RATIO_SCALE);
      ratio_prod = PROD_W'(ratio_thresh_ff) * PROD_W'(good_cnt);
      mode       = (good_cnt != '0) && (rep_prod >= ratio_prod);
      last       = !is_kmer && (cur_pos == right_pos);
   end

   // Advance read state
   always_ff @(posedge clock) begin
      if (reset) begin
         rep_cnt_ff  <= '0;
         garb_cnt_ff <= '0;
         next_in_ff  <= '0;
         next_out_ff <= '0;
      end else if (step_go) begin
         if (kmer_take) begin
            rep_cnt_ff  <= rep_in;
            garb_cnt_ff <= garb_in;
            next_in_ff  <= next_in_ff + POS_W'(1);
            if (kmer_emit) begin
               next_out_ff <= cur_pos + POS_W'(1);
            end
         end else if (drain_emit) begin
            if (last) begin
               rep_cnt_ff  <= '0;
               garb_cnt_ff <= '0;
               next_in_ff  <= '0;
               next_out_ff <= '0;
            end else begin
               rep_cnt_ff  <= rep_in;
               garb_cnt_ff <= garb_in;
               next_out_ff <= cur_pos + POS_W'(1);
            end
         end else if (drain_clear) begin
            rep_cnt_ff  <= '0;
            garb_cnt_ff <= '0;
            next_in_ff  <= '0;
            next_out_ff <= '0;
         end
      end
   end

   // Shift the class line; the tail is the class leaving the window
   always_ff @(posedge clock) begin
      if (shift_en) begin
         class_line_ff[0] <= new_cls;
         for (int i = 1; i < WIN_LEN; i++) begin
            class_line_ff[i] <= class_line_ff[i-1];
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step_go && has_result) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go && has_result) begin
         out_pos_ff  <= POS_OUT_W'(cur_pos);
         out_mode_ff <= mode;
         out_last_ff <= last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({out_mode_ff, out_pos_ff});
   assign rsp_tlast  = out_last_ff;

   // Window counts never exceed the window
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (32'(rep_cnt_ff) + 32'(garb_cnt_ff)) <= WIN_LEN)
      else $error("repeat plus garbage count exceeds window");

   // Output position never runs ahead of input position
   a_out_behind_in: assert property (@(posedge clock) disable iff (reset)
      next_out_ff <= next_in_ff)
      else $error("output position ahead of input position");

   // The last position of a read starts a new read
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (step_go && drain_emit && last) |=> (next_in_ff == '0) && (rep_cnt_ff == '0))
      else $error("read state not cleared after last position");

   // A result is loaded only when the slot is free or being drained
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (step_go && has_result && out_valid_ff) |-> rsp_tready)
      else $error("result register overwritten while stalled");

endmodule
